### src/fbde_pkg.sv
// ----------------------------------------------------------------------------
// fbde_pkg
// Shared widths, button indexes, command and status codes, and the
// structures passed between the debounce cells and the top level.
// ----------------------------------------------------------------------------
package fbde_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int DEBOUNCE_W  = 16;
    localparam int CMD_W       = 8;
    localparam int PLAY_CODE_W = 2;

    // Button positions in the level vector
    localparam int BTN_POWER = 0;
    localparam int BTN_PREV  = 1;
    localparam int BTN_NEXT  = 2;
    localparam int BTN_PLAY  = 3;
    localparam int BTN_LASER = 4;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_VIBRATE  = 8'h06;
    localparam logic [CMD_W-1:0] ARG_VIB_ON   = 8'h01;
    localparam logic [CMD_W-1:0] ARG_VIB_OFF  = 8'h00;

    // Play status codes
    localparam logic [PLAY_CODE_W-1:0] PLAY_CODE_NONE    = 2'd0;
    localparam logic [PLAY_CODE_W-1:0] PLAY_CODE_PLAYING = 2'd1;
    localparam logic [PLAY_CODE_W-1:0] PLAY_CODE_PAUSED  = 2'd2;

    // Accepted-level change reported by one debounce cell
    typedef struct packed {
        logic press;
        logic release_ev;
    } t_btn_event;

endpackage

### src/fbde_if.sv
// ----------------------------------------------------------------------------
// fbde_in_if / fbde_out_if
// Valid/ready channels for tick items into the block and result items out.
// ----------------------------------------------------------------------------
interface fbde_in_if
    import fbde_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [NUM_BUTTONS-1:0] button_levels;
    logic                   link_connected;
    logic                   command_valid;
    logic [CMD_W-1:0]       command_id;
    logic [CMD_W-1:0]       command_arg;

    modport source (
        output valid, button_levels, link_connected, command_valid,
               command_id, command_arg,
        input  ready
    );
    modport sink (
        input  valid, button_levels, link_connected, command_valid,
               command_id, command_arg,
        output ready
    );
endinterface

interface fbde_out_if
    import fbde_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   power_pressed;
    logic                   prev_pressed;
    logic                   next_pressed;
    logic                   play_pressed;
    logic [PLAY_CODE_W-1:0] play_code;
    logic                   laser_on;
    logic                   vibration_on;

    modport source (
        output valid, power_pressed, prev_pressed, next_pressed, play_pressed,
               play_code, laser_on, vibration_on,
        input  ready
    );
    modport sink (
        input  valid, power_pressed, prev_pressed, next_pressed, play_pressed,
               play_code, laser_on, vibration_on,
        output ready
    );
endinterface

### src/fbde_button.sv
// ----------------------------------------------------------------------------
// fbde_button
// Debounce cell for one button: stored raw level, saturating stable
// counter and accepted level, with press/release event detection.
// ----------------------------------------------------------------------------
module fbde_button
    import fbde_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic                  i_sample_en,
    input  logic                  i_raw,
    input  logic [DEBOUNCE_W-1:0] i_debounce_ticks,
    output t_btn_event            o_event
);

    localparam int CMP_W = (COUNT_WIDTH > DEBOUNCE_W) ? COUNT_WIDTH : DEBOUNCE_W;

    logic                   r_prev_raw;
    logic                   r_accepted;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   n_prev_raw;
    logic                   n_accepted;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] w_count_inc;
    logic                   w_stable;

    // Saturating increment
    assign w_count_inc = (&r_count) ? r_count : r_count + 1'b1;

    // Clear the count on a sampled raw change, otherwise count up
    assign n_count = (i_sample_en && (i_raw != r_prev_raw)) ? '0 : w_count_inc;

    assign w_stable = CMP_W'(n_count) > CMP_W'(i_debounce_ticks);

    // Next state of the cell and its event for this item
    always_comb begin
        n_prev_raw         = r_prev_raw;
        n_accepted         = r_accepted;
        o_event.press      = 1'b0;
        o_event.release_ev = 1'b0;
        if (i_sample_en) begin
            n_prev_raw = i_raw;
            if (w_stable) begin
                if (!i_raw && r_accepted) begin
                    n_accepted    = 1'b0;
                    o_event.press = 1'b1;
                end else if (i_raw && !r_accepted) begin
                    n_accepted         = 1'b1;
                    o_event.release_ev = 1'b1;
                end
            end
        end
    end

    // Hold state, advance once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw <= 1'b1;
            r_accepted <= 1'b1;
            r_count    <= '0;
        end else if (i_advance) begin
            r_prev_raw <= n_prev_raw;
            r_accepted <= n_accepted;
            r_count    <= n_count;
        end
    end

endmodule

### src/five_button_debounce_event_encoder.sv
// ----------------------------------------------------------------------------
// five_button_debounce_event_encoder
// Debounces five active-low buttons per tick item and encodes press events,
// play/pause status, laser drive and vibration drive.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one item per timer tick: raw button levels, the link
//   connected flag and an optional two-byte command. o_result returns exactly
//   one result item per tick item, in order.
//   An item is taken into an input register, then one pass of logic through
//   the five debounce cells and the play/laser/vibration state fills the
//   result register. o_result.valid rises when the result register is
//   loaded, which happens once that register is free or being taken.
//   Throughput is one item per cycle while o_result.ready stays high; it is
//   set by the single result register, and a new item is taken while a
//   result waits when the input register moves on in the same cycle.
//   When the receiver stalls, the result register holds, the input register
//   fills, and i_item.ready drops until o_result.ready returns.
//   i_cfg_we writes the debounce length (reset value 50); write only while
//   the block is idle.
//   Reset (i_rst_n low, synchronous) empties both registers, marks all
//   buttons released, clears counters, and turns playing, laser and
//   vibration off.
// ----------------------------------------------------------------------------
module five_button_debounce_event_encoder
    import fbde_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [DEBOUNCE_W-1:0] i_cfg_wdata,
    fbde_in_if.sink               i_item,
    fbde_out_if.source            o_result
);

    logic [DEBOUNCE_W-1:0]  r_debounce_ticks;

    logic                   r_in_valid;
    logic [NUM_BUTTONS-1:0] r_levels;
    logic                   r_link;
    logic                   r_cmd_valid;
    logic [CMD_W-1:0]       r_cmd_id;
    logic [CMD_W-1:0]       r_cmd_arg;

    logic                   r_out_valid;
    logic                   r_playing;
    logic                   r_laser;
    logic                   r_vibration;
    logic                   n_playing;
    logic                   n_laser;
    logic                   n_vibration;
    logic [PLAY_CODE_W-1:0] n_play_code;

    logic                   w_advance;
    logic [NUM_BUTTONS-1:0] w_sample_en;
    t_btn_event             w_event [NUM_BUTTONS];

    // Move the input item on when the result register is free or being taken
    assign w_advance    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_advance;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            r_debounce_ticks <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_levels    <= i_item.button_levels;
            r_link      <= i_item.link_connected;
            r_cmd_valid <= i_item.command_valid;
            r_cmd_id    <= i_item.command_id;
            r_cmd_arg   <= i_item.command_arg;
        end
    end

    // Power and laser always sample; prev, next and play only with the link up
    always_comb begin
        w_sample_en            = {NUM_BUTTONS{r_link}};
        w_sample_en[BTN_POWER] = 1'b1;
        w_sample_en[BTN_LASER] = 1'b1;
    end

    // One debounce cell per button
    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
        fbde_button #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_button (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_advance        (w_advance),
            .i_sample_en      (w_sample_en[b]),
            .i_raw            (r_levels[b]),
            .i_debounce_ticks (r_debounce_ticks),
            .o_event          (w_event[b])
        );
    end

    // Play toggle, laser follow and vibration command
    always_comb begin
        n_playing   = r_playing ^ w_event[BTN_PLAY].press;
        n_play_code = PLAY_CODE_NONE;
        if (w_event[BTN_PLAY].press) begin
            n_play_code = n_playing ? PLAY_CODE_PLAYING : PLAY_CODE_PAUSED;
        end

        n_laser = r_laser;
        if (w_event[BTN_LASER].press) begin
            n_laser = 1'b1;
        end else if (w_event[BTN_LASER].release_ev) begin
            n_laser = 1'b0;
        end

        n_vibration = r_vibration;
        if (r_cmd_valid && (r_cmd_id == CMD_VIBRATE)) begin
            if (r_cmd_arg == ARG_VIB_ON) begin
                n_vibration = 1'b1;
            end else if (r_cmd_arg == ARG_VIB_OFF) begin
                n_vibration = 1'b0;
            end
        end
    end

    // Hold block state across items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing   <= 1'b0;
            r_laser     <= 1'b0;
            r_vibration <= 1'b0;
        end else if (w_advance) begin
            r_playing   <= n_playing;
            r_laser     <= n_laser;
            r_vibration <= n_vibration;
        end
    end

    // Result register: load on advance, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            o_result.power_pressed <= w_event[BTN_POWER].press;
            o_result.prev_pressed  <= w_event[BTN_PREV].press;
            o_result.next_pressed  <= w_event[BTN_NEXT].press;
            o_result.play_pressed  <= w_event[BTN_PLAY].press;
            o_result.play_code     <= n_play_code;
            o_result.laser_on      <= n_laser;
            o_result.vibration_on  <= n_vibration;
        end
    end

    assign o_result.valid = r_out_valid;

endmodule
